[src/assert_macros.svh]
// Assertion macros shared by the matrix multiply-accumulate RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define MMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/mma_pkg.sv]
// Shared types and constants of the matrix multiply-accumulate unit.
package mma_pkg;

  // Field widths
  localparam int OP_W   = 3;
  localparam int IDX_W  = 5;
  localparam int AB_W   = 32;
  localparam int C_W    = 64;
  localparam int SIZE_W = 6;

  // Default largest matrix dimension and size register reset value
  localparam int               MAX_DIM_DEF = 32;
  localparam logic [SIZE_W-1:0] SIZE_RST   = 6'd32;

  // Command codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_LOAD_C = 3'd2,
    OP_MAC    = 3'd3,
    OP_READ_C = 3'd4
  } op_t;

  // Result kinds
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Sequencer memory strobes and completion flag
  typedef struct packed {
    logic ab_re;
    logic c_re;
    logic c_we;
    logic done;
  } seq_ctl_t;

endpackage

[src/mma_if.sv]
// Request and result channel interfaces of the matrix multiply-accumulate unit.
interface mma_in_if;
  import mma_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [C_W-1:0]   value;

  modport source (output valid, output op, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input op, input row, input col, input value,
                  output ready);
endinterface

interface mma_out_if;
  import mma_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [C_W-1:0]   data;

  modport source (output valid, output kind, output data, input ready);
  modport sink   (input valid, input kind, input data, output ready);
endinterface

[src/matrix_multiply_accumulate_unit.sv]
// Top level of the matrix multiply-accumulate unit: command decode, memories, result register.
//
// Usage:
//   in_chan carries requests (op, row, col, value) with valid/ready; a request is
//   taken at a rising edge with valid and ready high. Loads of A, B and C write one
//   element (none out of range) and give no result. A read of C gives one result (kind 1,
//   element data, zero for a row or column at or beyond MAX_DIM). A multiply-accumulate
//   request computes C += A * B over the active n by n corner and gives one result (kind 0).
//   out_chan carries results through one output register; cfg_wr_en writes the
//   matrix size register (zero acts as 1, values above MAX_DIM act as MAX_DIM).
// Timing:
//   A load writes its element when the request is taken, and loads follow back to back. A
//   read passes through the C memory read register and then the output register; the next
//   request can be taken in the cycle its result shows when the receiver takes the result.
//   A multiply walks every element of the active corner: each element issues n pairs of A
//   and B reads (one product per cycle through the single read port of each memory), then
//   waits for the MAC pipeline to drain before its C element is written.
// Reset: clears control state and sets the size register to 32; memory contents are
//   undefined until written. A stalled result holds the output register and no new
//   request is taken until it leaves.
`include "assert_macros.svh"

module matrix_multiply_accumulate_unit #(
  parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mma_pkg::SIZE_W-1:0]   cfg_wr_data,
  mma_in_if.sink                       in_chan,
  mma_out_if.source                    out_chan
);
  import mma_pkg::*;

  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_GEMM = 3'b100
  } top_state_t;

  top_state_t          state_r, state_nxt;
  logic [SIZE_W-1:0]   size_r;
  logic [NW-1:0]       dim_n;
  logic                accept;
  logic                in_range;
  logic [AW-1:0]       in_addr;
  logic                rd_zero_r;
  logic                a_we, b_we, c_load_we;
  logic                rd_issue, seq_start;
  logic                out_valid_r, out_kind_r;
  logic [C_W-1:0]      out_data_r;
  logic                out_load;
  logic                out_kind_nxt;
  logic [C_W-1:0]      out_data_nxt;
  seq_ctl_t            seq_ctl;
  logic [AW-1:0]       seq_a_raddr, seq_b_raddr, seq_c_addr;
  logic [C_W-1:0]      seq_c_wdata;
  logic [AB_W-1:0]     a_rdata, b_rdata;
  logic [C_W-1:0]      c_rdata;
  logic                c_we, c_re;
  logic [AW-1:0]       c_waddr, c_raddr;
  logic [C_W-1:0]      c_wdata;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RST;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // Clamp size to 1..MAX_DIM
  always_comb begin
    if (size_r == '0) begin
      dim_n = NW'(1);
    end else if (32'(size_r) > MAX_DIM) begin
      dim_n = NW'(MAX_DIM);
    end else begin
      dim_n = NW'(size_r);
    end
  end

  // Request handshake and address decode
  assign in_chan.ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept   = in_chan.valid && in_chan.ready;
  assign in_range = (32'(in_chan.row) < MAX_DIM) && (32'(in_chan.col) < MAX_DIM);
  assign in_addr  = AW'(in_chan.row) * AW'(MAX_DIM) + AW'(in_chan.col);

  // Command decode
  always_comb begin
    a_we      = 1'b0;
    b_we      = 1'b0;
    c_load_we = 1'b0;
    rd_issue  = 1'b0;
    seq_start = 1'b0;
    if (accept) begin
      unique case (op_t'(in_chan.op))
        OP_LOAD_A: a_we      = in_range;
        OP_LOAD_B: b_we      = in_range;
        OP_LOAD_C: c_load_we = in_range;
        OP_MAC:    seq_start = 1'b1;
        OP_READ_C: rd_issue  = 1'b1;
        default:   ;
      endcase
    end
  end

  // Control state
  always_comb begin
    state_nxt    = state_r;
    out_load     = 1'b0;
    out_kind_nxt = KIND_DONE;
    out_data_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (seq_start) begin
          state_nxt = S_GEMM;
        end else if (rd_issue) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        out_load     = 1'b1;
        out_kind_nxt = KIND_READ;
        out_data_nxt = rd_zero_r ? '0 : c_rdata;
        state_nxt    = S_IDLE;
      end
      S_GEMM: begin
        if (seq_ctl.done) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_chan.ready);
    end
  end

  // Result payload and out-of-range read flag
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_zero_r <= !in_range;
    end
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.kind  = out_kind_r;
  assign out_chan.data  = out_data_r;

  // C port sharing between host commands and the sequencer
  assign c_we    = c_load_we || seq_ctl.c_we;
  assign c_waddr = seq_ctl.c_we ? seq_c_addr : in_addr;
  assign c_wdata = seq_ctl.c_we ? seq_c_wdata : in_chan.value;
  assign c_re    = rd_issue || seq_ctl.c_re;
  assign c_raddr = seq_ctl.c_re ? seq_c_addr : in_addr;

  mma_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (in_addr),
    .wdata (in_chan.value[AB_W-1:0]),
    .re    (seq_ctl.ab_re),
    .raddr (seq_a_raddr),
    .rdata (a_rdata)
  );

  mma_ram #(.WIDTH(AB_W), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_addr),
    .wdata (in_chan.value[AB_W-1:0]),
    .re    (seq_ctl.ab_re),
    .raddr (seq_b_raddr),
    .rdata (b_rdata)
  );

  mma_ram #(.WIDTH(C_W), .DEPTH(DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  mma_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (seq_start),
    .dim_n   (dim_n),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .c_rdata (c_rdata),
    .ctl     (seq_ctl),
    .a_raddr (seq_a_raddr),
    .b_raddr (seq_b_raddr),
    .c_addr  (seq_c_addr),
    .c_wdata (seq_c_wdata)
  );

  `MMA_ASSERT_IMP(a_done_in_gemm, seq_ctl.done, state_r == S_GEMM, "multiply done outside gemm")
  `MMA_ASSERT_IMP(a_out_no_overwrite, out_load && out_valid_r, out_chan.ready, "result overwritten")
  `MMA_ASSERT(a_single_c_writer, !(c_load_we && seq_ctl.c_we), "two writers on C memory")

endmodule

[src/mma_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module mma_ram #(
  parameter int WIDTH = mma_pkg::AB_W,
  parameter int DEPTH = mma_pkg::MAX_DIM_DEF * mma_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/mma_seq.sv]
// Multiply-accumulate sequencer: walks i, j, k and runs the read-MAC-write pipeline.
`include "assert_macros.svh"

module mma_seq #(
  parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [$clog2(MAX_DIM+1)-1:0]           dim_n,
  input  logic [mma_pkg::AB_W-1:0]               a_rdata,
  input  logic [mma_pkg::AB_W-1:0]               b_rdata,
  input  logic [mma_pkg::C_W-1:0]                c_rdata,
  output mma_pkg::seq_ctl_t                      ctl,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     a_raddr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     b_raddr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     c_addr,
  output logic [mma_pkg::C_W-1:0]                c_wdata
);
  import mma_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_RUN  = 3'b010,
    SQ_WAIT = 3'b100
  } sq_state_t;

  sq_state_t            state_r, state_nxt;
  logic [IW-1:0]        i_r, i_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic [IW-1:0]        last_idx;
  logic                 issue, issue_last, issue_c;
  logic                 v1_r, last1_r, cld_r, v2_r, last2_r;
  logic signed [C_W-1:0] prod_nxt;
  logic [C_W-1:0]       prod_r;
  logic [C_W-1:0]       acc_r;
  logic [C_W-1:0]       sum;
  logic                 elem_last;

  assign last_idx = IW'(dim_n - NW'(1));

  // Issue-stage strobes
  assign issue      = (state_r == SQ_RUN);
  assign issue_last = issue && (k_r == last_idx);
  assign issue_c    = issue && (k_r == '0);
  assign elem_last  = (i_r == last_idx) && (j_r == last_idx);

  // Memory addresses: element (r, c) sits at r * MAX_DIM + c
  assign a_raddr = AW'(i_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_raddr = AW'(k_r) * AW'(MAX_DIM) + AW'(j_r);
  assign c_addr  = AW'(i_r) * AW'(MAX_DIM) + AW'(j_r);

  // Exact signed Q16.16 product in Q32.32
  assign prod_nxt = $signed(a_rdata) * $signed(b_rdata);
  assign sum      = acc_r + prod_r;
  assign c_wdata  = sum;

  assign ctl.ab_re = issue;
  assign ctl.c_re  = issue_c;
  assign ctl.c_we  = last2_r;
  assign ctl.done  = last2_r && elem_last;

  // Loop counters and state
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (start) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (k_r == last_idx) begin
          k_nxt     = '0;
          state_nxt = SQ_WAIT;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      SQ_WAIT: begin
        if (last2_r) begin
          if (elem_last) begin
            state_nxt = SQ_IDLE;
          end else if (j_r == last_idx) begin
            j_nxt     = '0;
            i_nxt     = i_r + IW'(1);
            state_nxt = SQ_RUN;
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = SQ_RUN;
          end
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // Hold state and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
      cld_r   <= 1'b0;
      v2_r    <= 1'b0;
      last2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      v1_r    <= issue;
      last1_r <= issue_last;
      cld_r   <= issue_c;
      v2_r    <= v1_r;
      last2_r <= last1_r;
    end
  end

  // Product and accumulator datapath
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cld_r) begin
      acc_r <= c_rdata;
    end else if (v2_r) begin
      acc_r <= sum;
    end
  end

  `MMA_ASSERT_IMP(a_cld_not_with_mac, cld_r, !v2_r, "accumulator load collides with a product")
  `MMA_ASSERT_IMP(a_write_in_wait, last2_r, state_r == SQ_WAIT, "C write outside wait state")
  `MMA_ASSERT_IMP(a_start_when_idle, start, state_r == SQ_IDLE, "start while sequencer busy")

endmodule
